FILE: rtl/core/scpf_pkg.sv
// ----------------------------------------------------------------------------
// Servo command packet framer package
// Shared types and constants for the short-packet framer: command and result
// request formats, operation codes and the fixed packet bytes.
// ----------------------------------------------------------------------------
package scpf_pkg;

    // Longest packet (angle command) in bytes.
    localparam int PKT_MAX_BYTES = 10;
    localparam int PKT_LEN_WIDTH = $clog2(PKT_MAX_BYTES + 1);

    // Fixed packet bytes.
    localparam logic [7:0] HDR_FIRST   = 8'hFA;
    localparam logic [7:0] HDR_SECOND  = 8'hAF;
    localparam logic [7:0] ADDR_TORQUE = 8'h24;
    localparam logic [7:0] ADDR_ANGLE  = 8'h1E;
    localparam logic [7:0] FLAGS_WRITE = 8'h00;
    localparam logic [7:0] FLAGS_READ  = 8'h0F;
    localparam logic [7:0] LEN_ONE     = 8'h01;
    localparam logic [7:0] LEN_TWO     = 8'h02;
    localparam logic [7:0] COUNT_ONE   = 8'h01;
    localparam logic [7:0] COUNT_NONE  = 8'h00;

    // Packet lengths in bytes, header and checksum included.
    localparam logic [PKT_LEN_WIDTH-1:0] TORQUE_PKT_LEN = PKT_LEN_WIDTH'(9);
    localparam logic [PKT_LEN_WIDTH-1:0] ANGLE_PKT_LEN  = PKT_LEN_WIDTH'(10);
    localparam logic [PKT_LEN_WIDTH-1:0] READ_PKT_LEN   = PKT_LEN_WIDTH'(8);

    // Operation codes. The fourth code is unused and drops the command.
    typedef enum logic [1:0] {
        OP_TORQUE = 2'd0,
        OP_ANGLE  = 2'd1,
        OP_READ   = 2'd2
    } operation_t;

    // One command request.
    typedef struct packed {
        logic [1:0]         operation;
        logic [7:0]         servo_id;
        logic signed [15:0] value;
        logic [7:0]         reg_address;
    } command_t;

    // One result request: a single packet byte.
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last;
    } result_t;

    // A whole packet, byte 0 first, with its length.
    typedef struct packed {
        logic [PKT_MAX_BYTES-1:0][7:0] bytes;
        logic [PKT_LEN_WIDTH-1:0]      len;
    } packet_t;

endpackage

FILE: rtl/core/scpf_builder.sv
// ----------------------------------------------------------------------------
// Packet builder
// Turns one registered command into the complete short packet, checksum
// included.
// ----------------------------------------------------------------------------
module scpf_builder (
    input  scpf_pkg::command_t cmd,
    output scpf_pkg::packet_t  pkt
);

    logic [15:0] angle_word;
    logic [7:0]  csum;

    // value * 10 as (value * 8) + (value * 2), modulo 2^16.
    assign angle_word = {cmd.value[12:0], 3'b000} + {cmd.value[14:0], 1'b0};

    always_comb begin
        pkt       = '0;
        csum      = '0;
        pkt.bytes[0] = scpf_pkg::HDR_FIRST;
        pkt.bytes[1] = scpf_pkg::HDR_SECOND;
        pkt.bytes[2] = cmd.servo_id;
        unique case (cmd.operation)
            scpf_pkg::OP_TORQUE: begin
                pkt.bytes[3] = scpf_pkg::FLAGS_WRITE;
                pkt.bytes[4] = scpf_pkg::ADDR_TORQUE;
                pkt.bytes[5] = scpf_pkg::LEN_ONE;
                pkt.bytes[6] = scpf_pkg::COUNT_ONE;
                pkt.bytes[7] = cmd.value[7:0];
                csum = pkt.bytes[2] ^ pkt.bytes[3] ^ pkt.bytes[4] ^ pkt.bytes[5]
                     ^ pkt.bytes[6] ^ pkt.bytes[7];
                pkt.bytes[8] = csum;
                pkt.len      = scpf_pkg::TORQUE_PKT_LEN;
            end
            scpf_pkg::OP_ANGLE: begin
                pkt.bytes[3] = scpf_pkg::FLAGS_WRITE;
                pkt.bytes[4] = scpf_pkg::ADDR_ANGLE;
                pkt.bytes[5] = scpf_pkg::LEN_TWO;
                pkt.bytes[6] = scpf_pkg::COUNT_ONE;
                pkt.bytes[7] = angle_word[7:0];
                pkt.bytes[8] = angle_word[15:8];
                csum = pkt.bytes[2] ^ pkt.bytes[3] ^ pkt.bytes[4] ^ pkt.bytes[5]
                     ^ pkt.bytes[6] ^ pkt.bytes[7] ^ pkt.bytes[8];
                pkt.bytes[9] = csum;
                pkt.len      = scpf_pkg::ANGLE_PKT_LEN;
            end
            scpf_pkg::OP_READ: begin
                pkt.bytes[3] = scpf_pkg::FLAGS_READ;
                pkt.bytes[4] = cmd.reg_address;
                pkt.bytes[5] = scpf_pkg::LEN_TWO;
                pkt.bytes[6] = scpf_pkg::COUNT_NONE;
                csum = pkt.bytes[2] ^ pkt.bytes[3] ^ pkt.bytes[4] ^ pkt.bytes[5]
                     ^ pkt.bytes[6];
                pkt.bytes[7] = csum;
                pkt.len      = scpf_pkg::READ_PKT_LEN;
            end
            default: begin
                // Unused code is never loaded into the serializer; length zero.
                pkt.len = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/scpf_serializer.sv
// ----------------------------------------------------------------------------
// Packet serializer
// Holds one packet in a shift register and moves it out one byte per cycle,
// while the receiver does not stall, through a registered result port, marking the final byte.
// ----------------------------------------------------------------------------
module scpf_serializer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  scpf_pkg::packet_t   pkt,
    output logic                can_load,
    output logic                m_valid,
    input  logic                m_ready,
    output scpf_pkg::result_t   m_data
);

    localparam int N = scpf_pkg::PKT_MAX_BYTES;

    logic [N-1:0][7:0]                     bytes_reg, bytes_next;
    logic [scpf_pkg::PKT_LEN_WIDTH-1:0]    remain_reg, remain_next;
    logic                                  busy_reg, busy_next;
    logic                                  m_valid_reg, m_valid_next;
    scpf_pkg::result_t                     m_data_reg, m_data_next;

    logic out_free;
    logic take;
    logic last_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign take      = busy_reg && out_free;
    assign last_byte = (remain_reg == scpf_pkg::PKT_LEN_WIDTH'(1));
    assign can_load  = !busy_reg || (take && last_byte);

    always_comb begin
        bytes_next  = bytes_reg;
        remain_next = remain_reg;
        busy_next   = busy_reg;
        if (load) begin
            bytes_next  = pkt.bytes;
            remain_next = pkt.len;
            busy_next   = 1'b1;
        end else if (take) begin
            for (int i = 0; i < N - 1; i++) begin
                bytes_next[i] = bytes_reg[i+1];
            end
            bytes_next[N-1] = '0;
            remain_next     = remain_reg - scpf_pkg::PKT_LEN_WIDTH'(1);
            busy_next       = !last_byte;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_free) begin
            m_valid_next        = take;
            m_data_next.tx_byte = bytes_reg[0];
            m_data_next.last    = last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            remain_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            remain_reg  <= remain_next;
            m_valid_reg <= m_valid_next;
        end
        bytes_reg  <= bytes_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: rtl/core/servo_command_packet_framer.sv
// ----------------------------------------------------------------------------
// Servo command packet framer
// Frames torque, angle and register read commands as serial short packets.
// ----------------------------------------------------------------------------
// Usage:
// A command request enters on s_data (operation, servo id, value, register
// address) with s_valid/s_ready. The packet leaves on m_data as one byte per
// request with m_valid/m_ready; the checksum byte that ends a packet has
// last set. Torque packets are 9 bytes, angle packets 10, read requests 8.
// A command with the unused operation code is accepted and dropped.
// Latency: the first byte of a packet passes the command register, the
// packet shift register and the result register after its command is
// accepted. Throughput: the result port moves one byte per cycle while the
// receiver does not stall; packets follow with no gap when a command waits.
// A command register in front of the packet shift register lets the next
// command be accepted while the current packet is still being sent.
// When the receiver stalls, the byte in the result register holds and the
// shift register and command register hold behind it; s_ready drops once
// the command register is full. Synchronous active-low reset empties all
// stages; no packet is in flight afterwards.
// ----------------------------------------------------------------------------
module servo_command_packet_framer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scpf_pkg::command_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output scpf_pkg::result_t   m_data
);

    // Command register: holds the next command until the serializer is free.
    scpf_pkg::command_t cmd_reg, cmd_next;
    logic               cmd_valid_reg, cmd_valid_next;

    scpf_pkg::packet_t  pkt;
    logic               can_load;
    logic               load;
    logic               accept;
    logic               op_used;

    // The unused operation code produces no packet, so it never fills the
    // command register.
    assign op_used = (s_data.operation == scpf_pkg::OP_TORQUE)
                  || (s_data.operation == scpf_pkg::OP_ANGLE)
                  || (s_data.operation == scpf_pkg::OP_READ);

    assign load    = cmd_valid_reg && can_load;
    assign s_ready = !cmd_valid_reg || load;
    assign accept  = s_valid && s_ready;

    always_comb begin
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !load;
        if (accept) begin
            cmd_next       = s_data;
            cmd_valid_next = op_used;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else begin
            cmd_valid_reg <= cmd_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    // The packet is built combinationally between the command register and
    // the serializer's shift register.
    scpf_builder u_builder (
        .cmd (cmd_reg),
        .pkt (pkt)
    );

    scpf_serializer u_serializer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .pkt      (pkt),
        .can_load (can_load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A dropped command leaves the command register empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !op_used) |=> !cmd_valid_reg)
        else $error("unused operation code reached the command register");

    // Bytes of one packet leave back to back once the receiver takes them.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_data.last) |=> m_valid)
        else $error("gap inside a packet");

    // A waiting command is not overwritten while the input is held off.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_valid_reg && !s_ready) |=> (cmd_valid_reg && $stable(cmd_reg)))
        else $error("pending command lost or changed");

endmodule
